/* rtl/sync_crc32_range_deframer_defines.svh */
// ----------------------------------------------------------------------------
// sync_crc32_range_deframer_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SYNC_CRC32_RANGE_DEFRAMER_DEFINES_SVH
`define SYNC_CRC32_RANGE_DEFRAMER_DEFINES_SVH

// same-cycle implication, off during reset
`define SCRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrd assertion failed");

// next-cycle implication, off during reset
`define SCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrd assertion failed");

`endif

/* rtl/scrd_pkg.sv */
// ----------------------------------------------------------------------------
// scrd_pkg
// constants and types for the sync word deframer with crc-32 check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scrd_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int RANGE_W     = 32;
    localparam int CRC_W       = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [7:0]       SYNC_FIRST  = 8'h85;
    localparam logic [7:0]       SYNC_SECOND = 8'hA4;
    localparam logic [CRC_W-1:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFFFFFF;

    // result word, range bits in the lowest bits
    typedef struct packed {
        logic [OUT_TDATA_W-RANGE_W-2:0] pad;
        logic                           crc_ok;
        logic [RANGE_W-1:0]             range_bits;
    } t_out_data;

endpackage

`default_nettype wire

/* rtl/scrd_crc8.sv */
// ----------------------------------------------------------------------------
// scrd_crc8
// reflected crc-32 register update over one byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scrd_crc8 (
    input  wire logic [scrd_pkg::CRC_W-1:0] i_crc,
    input  wire logic [7:0]                 i_byte,
    output logic      [scrd_pkg::CRC_W-1:0] o_crc
);
    import scrd_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] v_crc;
        v_crc = i_crc ^ {{(CRC_W-8){1'b0}}, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

`default_nettype wire

/* rtl/sync_crc32_range_deframer.sv */
// ----------------------------------------------------------------------------
// sync_crc32_range_deframer: the last crc byte is registered in the input stage,
// then its result in the result stage; 1 byte per cycle unless a result stalls
// at the output, using the combinational byte-wide crc update; synchronous
// active-low reset clears the input and result stages and restarts the sync hunt; a pending result is dropped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sync_crc32_range_deframer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [scrd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,   // rx_byte
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic      [scrd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata    // range_bits, crc_ok, zero pad
);
    import scrd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    logic                  r_in_valid, n_in_valid;
    logic [IN_TDATA_W-1:0] r_in_byte, n_in_byte;
    t_phase                r_phase, n_phase;
    logic [1:0]            r_byte_count, n_byte_count;
    logic [CRC_W-1:0]      r_crc, n_crc;
    logic [RANGE_W-1:0]    r_payload, n_payload;
    logic [CRC_W-1:0]      r_rx_crc, n_rx_crc;
    logic                  r_out_valid, n_out_valid;
    t_out_data             r_out_data, n_out_data;

    logic                  w_crc_next_valid;
    logic [CRC_W-1:0]      w_crc_next;
    logic                  w_last;
    logic                  w_adv;
    logic                  w_in_ready;

    scrd_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_byte (r_in_byte),
        .o_crc  (w_crc_next)
    );

    assign w_crc_next_valid = (r_phase == PH_PAYLOAD);
    assign w_last     = (r_phase == PH_CRC) && (r_byte_count == 2'd3);
    assign w_adv      = r_in_valid && (!w_last || !r_out_valid || i_m_axis_tready);
    assign w_in_ready = !r_in_valid || w_adv;

    always_comb begin
        n_in_valid   = r_in_valid;
        n_in_byte    = r_in_byte;
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_payload    = r_payload;
        n_rx_crc     = r_rx_crc;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;

        if (w_in_ready) begin
            n_in_valid = i_s_axis_tvalid;
            n_in_byte  = i_s_axis_tdata;
        end

        if (w_adv) begin
            unique case (r_phase)
                PH_HUNT1: begin
                    if (r_in_byte == SYNC_FIRST) begin
                        n_phase = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (r_in_byte == SYNC_SECOND) begin
                        n_phase      = PH_PAYLOAD;
                        n_byte_count = 2'd0;
                        n_crc        = CRC_INIT;
                        n_payload    = '0;
                        n_rx_crc     = '0;
                    end else if (r_in_byte != SYNC_FIRST) begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_PAYLOAD: begin
                    if (w_crc_next_valid) begin
                        n_crc = w_crc_next;
                    end
                    n_payload = {r_in_byte, r_payload[RANGE_W-1:8]};
                    if (r_byte_count == 2'd3) begin
                        n_byte_count = 2'd0;
                        n_phase      = PH_CRC;
                    end else begin
                        n_byte_count = r_byte_count + 2'd1;
                    end
                end
                PH_CRC: begin
                    n_rx_crc = {r_in_byte, r_rx_crc[CRC_W-1:8]};
                    if (r_byte_count != 2'd3) begin
                        n_byte_count = r_byte_count + 2'd1;
                    end else begin
                        n_byte_count          = 2'd0;
                        n_phase               = PH_HUNT1;
                        n_out_valid           = 1'b1;
                        n_out_data.pad        = '0;
                        n_out_data.crc_ok     = (n_rx_crc == ~r_crc);
                        n_out_data.range_bits = r_payload;
                    end
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte  <= n_in_byte;
        r_crc      <= n_crc;
        r_payload  <= n_payload;
        r_rx_crc   <= n_rx_crc;
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_HUNT1;
            r_byte_count <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* rtl/scrd_checker.sv */
// ----------------------------------------------------------------------------
// scrd_checker
// port-level checks on the deframer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sync_crc32_range_deframer_defines.svh"

module scrd_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    input  wire logic                                o_s_axis_tready,
    input  wire logic [scrd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  wire logic                                o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    input  wire logic [scrd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import scrd_pkg::*;

    logic w_in_xfer;
    logic w_pad_zero;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pad_zero = (o_m_axis_tdata[OUT_TDATA_W-1:RANGE_W+1] == '0);

    // a stalled result stays
    `SCRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `SCRD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata))
    // padding above the flag is zero whenever a result is valid
    `SCRD_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, w_pad_zero)
    // no result straight out of reset
    `SCRD_ASSERT_NOW(a_reset_quiet, i_clk, i_rst_n, $rose(i_rst_n), !o_m_axis_tvalid && !w_in_xfer || !o_m_axis_tvalid)

endmodule

bind sync_crc32_range_deframer scrd_checker u_scrd_checker (.*);

`default_nettype wire

/* test/sync_crc32_range_deframer_tb.sv */
// ----------------------------------------------------------------------------
// sync_crc32_range_deframer_tb
// feeds received bytes into the deframer as stream transfers, directed frames
// first and then a random mix of well-formed frames, broken syncs and noise;
// an in-bench predictor tracks the sync hunt and crc-32, and every result
// transfer is checked against the oldest predicted frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_crc32_range_deframer_tb;

    import scrd_pkg::*;

    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        TAKE_RANGE,
        TAKE_CRC
    } t_frame_phase;

    typedef struct {
        logic [RANGE_W-1:0] range_bits;
        logic               crc_ok;
    } t_range_frame;

    localparam int BYTE_TARGET = 1450;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_LEN    = 250;
    localparam int QUIET_FROM  = 1200;
    localparam int QUIET_TO    = 1700;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;   // rx_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;         // range_bits, crc_ok, zero pad

    sync_crc32_range_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    logic [7:0]   rx_bytes_q[$];
    t_range_frame frames_expected[$];

    t_frame_phase      frame_phase = SEEK_FIRST;
    logic [1:0]        field_count = '0;
    logic [CRC_W-1:0]  crc_run     = CRC_INIT;
    logic [RANGE_W-1:0] range_acc  = '0;
    logic [CRC_W-1:0]  crc_rx      = '0;

    int  err_count    = 0;
    int  bytes_in     = 0;
    int  frames_seen  = 0;
    int  frames_bad   = 0;
    int  cyc          = 0;
    int  hold_cycles  = 0;
    bit  byte_taken   = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bit gap_roll();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < 26;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // follows the deframer one accepted byte at a time
    task automatic track_byte(input logic [7:0] b);
        t_range_frame f;
        case (frame_phase)
            SEEK_FIRST: begin
                if (b == SYNC_FIRST) frame_phase = SEEK_SECOND;
            end
            SEEK_SECOND: begin
                if (b == SYNC_SECOND) begin
                    frame_phase = TAKE_RANGE;
                    field_count = '0;
                    crc_run     = CRC_INIT;
                    range_acc   = '0;
                    crc_rx      = '0;
                end else if (b != SYNC_FIRST) begin
                    frame_phase = SEEK_FIRST;
                end
            end
            TAKE_RANGE: begin
                crc_run   = crc32_byte(crc_run, b);
                range_acc = {b, range_acc[31:8]};
                if (field_count == 2'd3) frame_phase = TAKE_CRC;
                field_count = field_count + 2'd1;
            end
            TAKE_CRC: begin
                crc_rx = {b, crc_rx[31:8]};
                if (field_count == 2'd3) begin
                    frame_phase  = SEEK_FIRST;
                    f.range_bits = range_acc;
                    f.crc_ok     = (crc_rx == ~crc_run);
                    frames_expected.push_back(f);
                end
                field_count = field_count + 2'd1;
            end
        endcase
    endtask

    task automatic queue_frame(input logic [31:0] range, input bit corrupt,
                               input bit twin_first, inout int items);
        logic [CRC_W-1:0] crc;
        crc = CRC_INIT;
        for (int k = 0; k < 4; k++) crc = crc32_byte(crc, range[8*k +: 8]);
        crc = ~crc;
        if (corrupt) crc = crc ^ ($urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31))
                                                       : ($urandom() | 32'h1));
        if (twin_first) rx_bytes_q.push_back(SYNC_FIRST);
        rx_bytes_q.push_back(SYNC_FIRST);
        rx_bytes_q.push_back(SYNC_SECOND);
        for (int k = 0; k < 4; k++) rx_bytes_q.push_back(range[8*k +: 8]);
        for (int k = 0; k < 4; k++) rx_bytes_q.push_back(crc[8*k +: 8]);
        items += twin_first ? 11 : 10;
    endtask

    function automatic logic [31:0] pick_range();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return {SYNC_SECOND, SYNC_FIRST, SYNC_SECOND, SYNC_FIRST};
            default: return $urandom();
        endcase
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == HOLD_AT) begin
            hold_cycles <= HOLD_LEN;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || byte_taken)) begin
            byte_taken = 1'b0;
            if (rx_bytes_q.size() != 0 && !gap_roll()) begin
                i_s_axis_tdata  <= rx_bytes_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= (hold_cycles == 0) && !gap_roll();
    end

    always @(posedge i_clk) begin
        t_out_data    res;
        t_range_frame want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                track_byte(i_s_axis_tdata);
                byte_taken = 1'b1;
                bytes_in++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                res = t_out_data'(o_m_axis_tdata);
                if (frames_expected.size() == 0) begin
                    report_mismatch("unexpected result", res.range_bits, 32'h0);
                end else begin
                    want = frames_expected.pop_front();
                    frames_seen++;
                    if (!want.crc_ok) frames_bad++;
                    if (res.range_bits !== want.range_bits)
                        report_mismatch("range_bits", res.range_bits, want.range_bits);
                    if (res.crc_ok !== want.crc_ok)
                        report_mismatch("crc_ok", {31'h0, res.crc_ok}, {31'h0, want.crc_ok});
                    if (res.pad !== '0)
                        report_mismatch("pad", {25'h0, res.pad}, 32'h0);
                end
            end
        end
    end

    initial begin
        int items;
        int pick;
        logic [7:0] b;
        items = 0;

        // broken sync: the a4 after a wrong byte must not start a frame
        rx_bytes_q.push_back(SYNC_FIRST);
        rx_bytes_q.push_back(8'h12);
        rx_bytes_q.push_back(SYNC_SECOND);
        items += 3;
        // repeated first sync byte, all-zero range, good crc
        queue_frame(32'h0, 1'b0, 1'b1, items);
        // sync pattern and an all-ones byte inside the payload, bad crc
        queue_frame({8'hFF, SYNC_FIRST, SYNC_SECOND, SYNC_FIRST}, 1'b1, 1'b0, items);

        while (items < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_frame(pick_range(), $urandom_range(0, 4) == 0,
                            $urandom_range(0, 7) == 0, items);
            end else if (pick < 85) begin
                rx_bytes_q.push_back(SYNC_FIRST);
                do b = 8'($urandom_range(0, 255)); while (b == SYNC_SECOND);
                rx_bytes_q.push_back(b);
                items += 2;
                if ($urandom_range(0, 1)) begin
                    rx_bytes_q.push_back(SYNC_SECOND);
                    items++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom_range(0, 255));
                    rx_bytes_q.push_back(b);
                    items++;
                end
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (rx_bytes_q.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (frames_expected.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes through the deframer, checked %0d frames (%0d with bad crc)",
                 bytes_in, frames_seen, frames_bad);
        $display("with random gaps on both sides and one long output stall; %0d mismatches",
                 err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
